@@ design/csit_pkg.sv @@
package csit_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CENTER_WIDTH    = 16;
   localparam int RADIUS_WIDTH    = 15;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIUS   = 2'd2;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL1,
      ST_MUL2,
      ST_SUMS,
      ST_SQ,
      ST_DISC,
      ST_SQRT,
      ST_CMP,
      ST_OUT
   } csit_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic diff;
      logic mul1;
      logic mul2;
      logic sums;
      logic sq;
      logic disc;
      logic sqrt_init;
      logic sqrt_step;
      logic compare;
   } csit_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sqrt_done;
   } csit_sts_type;

endpackage

@@ design/circle_segment_intersect_test.sv @@
// Segment versus circle hit test. Each request word carries one segment and a
// last-of-list mark; one response word per segment returns its hit flag, the
// OR of hits in the list so far, and the list end mark. Segments are handled
// one at a time: the next request is taken only when idle or together with
// the response of the previous segment. The time per segment is set mostly by
// the restoring square root that yields one root bit per cycle; a response
// is held while rsp_tready is low. The circle is to be set through the csr port
// while no segment is in flight; the block itself does not enforce this.
module circle_segment_intersect_test
   import csit_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // segment_hit, list_hit from the lowest bit up
   output logic [7:0]                    rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   logic signed [CENTER_WIDTH-1:0] center_x_ff, center_y_ff;
   logic [RADIUS_WIDTH-1:0]        radius_ff;
   csit_cmd_type cmd;
   csit_sts_type sts;
   logic seg_hit, lst_hit, lst_done;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   csit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   csit_dp #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .start_x      (req_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
      .start_y      (req_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
      .end_x        (req_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
      .end_y        (req_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
      .last_in_list (req_tlast),
      .center_x     (center_x_ff),
      .center_y     (center_y_ff),
      .radius       (radius_ff),
      .cmd          (cmd),
      .sts          (sts),
      .segment_hit  (seg_hit),
      .list_hit     (lst_hit),
      .list_done    (lst_done)
   );

   assign rsp_tdata = {6'b0, lst_hit, seg_hit};
   assign rsp_tlast = lst_done;

   // A hit on this segment always shows in the list flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("segment hit without list hit");

   // No new request is taken while a response is pending and stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted during stalled response");

   // A response follows only after the compare step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.compare))
      else $error("response without compare");

endmodule

@@ design/csit_ctrl.sv @@
module csit_ctrl
   import csit_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  csit_sts_type sts,
   output csit_cmd_type cmd
);

   csit_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_SUMS;
         end
         ST_SUMS: begin
            cmd.sums = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_DISC;
         end
         ST_DISC: begin
            cmd.disc      = 1'b1;
            cmd.sqrt_init = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready) begin
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIFF;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ design/csit_dp.sv @@
module csit_dp
   import csit_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [COORD_WIDTH-1:0]    start_x,
   input  logic signed [COORD_WIDTH-1:0]    start_y,
   input  logic signed [COORD_WIDTH-1:0]    end_x,
   input  logic signed [COORD_WIDTH-1:0]    end_y,
   input  logic                             last_in_list,
   input  logic signed [CENTER_WIDTH-1:0]   center_x,
   input  logic signed [CENTER_WIDTH-1:0]   center_y,
   input  logic        [RADIUS_WIDTH-1:0]   radius,
   input  csit_cmd_type                     cmd,
   output csit_sts_type                     sts,
   output logic                             segment_hit,
   output logic                             list_hit,
   output logic                             list_done
);

   // Difference widths: d and e fit in one bit more than their operands.
   localparam int DW = COORD_WIDTH + 1;
   localparam int EW = ((COORD_WIDTH > CENTER_WIDTH) ? COORD_WIDTH : CENTER_WIDTH) + 1;
   localparam int PW = 2 * EW;          // one product
   localparam int SW = PW + 2;          // sums of two products, signed
   localparam int QW = 2 * SW;          // b*b and A*C magnitudes
   localparam int XW = QW + 2 + 2 * FRAC_BITS;  // radicand, even so bit pairs align
   localparam int RW = (XW + 1) / 2;            // root
   localparam int CW = $clog2(RW + 1);          // counter of root bits
   localparam int KW = SW + FRAC_BITS + 2;      // compare width

   logic signed [DW-1:0] dx_ff, dy_ff;
   logic signed [EW-1:0] ex_ff, ey_ff;
   logic signed [COORD_WIDTH-1:0] sx_ff, sy_ff, ex_in_ff, ey_in_ff;
   logic                 last_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [SW-1:0] a_ff, b_ff, c_ff;
   logic [SW-1:0]        bmag, cmag;
   logic [QW-1:0]        bsq_ff, ac_ff;
   logic                 zero_a_ff, miss_ff, hit_ff, sticky_ff;
   logic                 list_ff;
   logic [XW-1:0]        rad_ff, rem_ff;
   logic [RW-1:0]        root_ff;
   logic [CW-1:0]        cnt_ff;
   logic [RW-1:0]        pidx;
   logic [XW+1:0]        trial;
   logic [XW+1:0]        rem_sh;
   logic [QW:0]          dsum;
   logic [KW-1:0]        bm, kk, ss;
   logic                 lo1, hi1, lo2, hi2, bneg, bpos, hit;

   assign bmag = b_ff[SW-1] ? SW'(-b_ff) : SW'(b_ff);
   assign cmag = c_ff[SW-1] ? SW'(-c_ff) : SW'(c_ff);

   // Operand capture, differences, the products of the mul1 and mul2 steps, sums and squares.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sx_ff    <= start_x;
         sy_ff    <= start_y;
         ex_in_ff <= end_x;
         ey_in_ff <= end_y;
         last_ff  <= last_in_list;
      end
      if (cmd.diff) begin
         dx_ff <= DW'(ex_in_ff) - DW'(sx_ff);
         dy_ff <= DW'(ey_in_ff) - DW'(sy_ff);
         ex_ff <= EW'(sx_ff) - EW'(center_x);
         ey_ff <= EW'(sy_ff) - EW'(center_y);
      end
      if (cmd.mul1) begin
         p0_ff <= PW'(dx_ff) * PW'(dx_ff);
         p1_ff <= PW'(dy_ff) * PW'(dy_ff);
         p2_ff <= PW'(dx_ff) * PW'(ex_ff);
      end
      if (cmd.mul2) begin
         p3_ff <= PW'(dy_ff) * PW'(ey_ff);
         p4_ff <= PW'(ex_ff) * PW'(ex_ff) + PW'(ey_ff) * PW'(ey_ff);
         p5_ff <= PW'({1'b0, radius}) * PW'({1'b0, radius});
      end
      if (cmd.sums) begin
         a_ff <= SW'(p0_ff) + SW'(p1_ff);
         b_ff <= SW'(p2_ff) + SW'(p3_ff);
         c_ff <= SW'(p4_ff) - SW'(p5_ff);
      end
      if (cmd.sq) begin
         bsq_ff    <= QW'(bmag) * QW'(bmag);
         ac_ff     <= QW'(a_ff) * QW'(cmag);
         zero_a_ff <= (a_ff == '0);
      end
   end

   // Discriminant and root: one result bit per cycle, restoring method.
   assign dsum   = (c_ff[SW-1] || c_ff == '0) ? ({1'b0, bsq_ff} + {1'b0, ac_ff})
                                              : ({1'b0, bsq_ff} - {1'b0, ac_ff});
   assign pidx   = RW'(cnt_ff - 1'b1);
   assign rem_sh = {rem_ff, rad_ff[XW-1 -: 2]};
   assign trial  = rem_sh - {XW'(root_ff), 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.disc) begin
         miss_ff <= !(c_ff[SW-1] || c_ff == '0) && (bsq_ff < ac_ff);
         rad_ff  <= XW'(dsum) << (2 * FRAC_BITS);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (!trial[XW+1]) begin
            rem_ff  <= XW'(trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= XW'(rem_sh);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.sqrt_init) begin
         cnt_ff <= CW'(RW);
      end else if (cmd.sqrt_step && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end
   assign sts.sqrt_done = (cnt_ff == CW'(1)) || (pidx == '0 && cnt_ff == '0);

   // Root window checks: a hit needs either crossing to satisfy 0 <= t <= 1.
   assign bm   = KW'(bmag) << FRAC_BITS;
   assign kk   = (KW'(a_ff) << FRAC_BITS) + KW'(a_ff);
   assign ss   = KW'(root_ff);
   assign bneg = b_ff[SW-1];
   assign bpos = !b_ff[SW-1] && (b_ff != '0);
   assign lo1  = !bpos && (bm >= ss);
   assign hi1  = !bneg || (bm < kk + ss);
   assign lo2  = !bpos || (ss >= bm);
   assign hi2  = !bneg ? (ss < kk + bm) : (ss + bm < kk);
   assign hit  = !zero_a_ff && !miss_ff && ((lo1 && hi1) || (lo2 && hi2));

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff <= hit;
      end
   end

   // Sticky list flag, updated at the compare step.
   always_ff @(posedge clock) begin
      if (reset) begin
         sticky_ff <= 1'b0;
      end else if (cmd.compare) begin
         sticky_ff <= last_ff ? 1'b0 : (sticky_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         list_ff <= sticky_ff || hit;
      end
   end

   assign segment_hit = hit_ff;
   assign list_hit    = list_ff;
   assign list_done   = last_ff;

endmodule
